// ===== src/cpla_pkg.sv =====
package cpla_pkg;

  localparam int unsigned FIXED_SLOTS = 64;
  localparam int unsigned PAIR_CAPACITY_DEFAULT = 256;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned KEY_W = 2 * COLOR_W;
  localparam int unsigned MAX_PAIRS_W = 9;
  localparam int unsigned PAIR_INDEX_W = 8;

  localparam logic [MAX_PAIRS_W-1:0] MAX_PAIRS_RESET = 9'd256;

  // Opcode values of an input item.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

// ===== src/cpla_ram.sv =====
module cpla_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 192
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/color_pair_lookup_allocate.sv =====
// Color-pair slot allocator.
//
// An item is taken at a rising edge with start_i high and busy_o low. A get
// item (opcode 0) returns the slot for its foreground/background colors; a
// clear item (opcode 1) frees every dynamic slot and returns slot 0.
// The result shows on pair_index_o, newly_allocated_o and table_full_o for
// exactly one cycle, marked by done_o; the receiver cannot hold it off.
//
// A clear item or a pair with both colors below 8 gives its result in the
// cycle after it is taken. Any other pair scans the allocated dynamic
// slots one per cycle through the read port of the pair table, until a
// match or until all N slots in use are read (N at most PAIR_CAPACITY-64,
// 192 at the default capacity). busy_o is high for the whole scan; a new
// item may be taken in the cycle in which done_o is shown.
//
// The slot limit max_pairs_i is written whenever max_pairs_we_i is high, and
// should only change while the block is idle. Reset sets the limit to 256
// and frees all dynamic slots; the pair table itself needs no clearing.
module color_pair_lookup_allocate
  import cpla_pkg::*;
#(
  parameter int unsigned PAIR_CAPACITY = PAIR_CAPACITY_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    opcode_i,
  input  logic [COLOR_W-1:0]      fg_color_i,
  input  logic [COLOR_W-1:0]      bg_color_i,
  input  logic                    max_pairs_we_i,
  input  logic [MAX_PAIRS_W-1:0]  max_pairs_i,
  output logic                    done_o,
  output logic [PAIR_INDEX_W-1:0] pair_index_o,
  output logic                    newly_allocated_o,
  output logic                    table_full_o
);

  localparam int unsigned DYN_SLOTS = PAIR_CAPACITY - FIXED_SLOTS;
  localparam int unsigned AW = (DYN_SLOTS > 1) ? $clog2(DYN_SLOTS) : 1;
  localparam int unsigned UW = $clog2(PAIR_CAPACITY + 1);
  localparam int unsigned CW = (UW > MAX_PAIRS_W) ? UW : MAX_PAIRS_W;
  localparam int unsigned SW = (UW > PAIR_INDEX_W) ? UW : PAIR_INDEX_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                  state_q, state_d;
  logic [MAX_PAIRS_W-1:0]  max_pairs_q, max_pairs_d;
  logic [UW-1:0]           used_count_q, used_count_d;
  logic [UW-1:0]           ptr_q, ptr_d;
  logic [UW-1:0]           cmp_ptr_q, cmp_ptr_d;
  logic                    cmp_valid_q, cmp_valid_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic                    done_q, done_d;
  logic [PAIR_INDEX_W-1:0] pair_index_q, pair_index_d;
  logic                    newly_q, newly_d;
  logic                    full_q, full_d;

  logic [UW-1:0]    used_dyn;
  logic [CW-1:0]    used_ext;
  logic [CW-1:0]    limit;
  logic             no_free;
  logic [SW-1:0]    hit_slot;
  logic [SW-1:0]    new_slot;
  logic             ram_we;
  logic             ram_re;
  logic [KEY_W-1:0] ram_rdata;

  assign used_dyn = used_count_q - UW'(FIXED_SLOTS);
  assign used_ext = CW'(used_count_q);
  // The limit saturates at the table capacity.
  assign limit = (CW'(max_pairs_q) > CW'(PAIR_CAPACITY)) ? CW'(PAIR_CAPACITY)
                                                         : CW'(max_pairs_q);
  assign no_free = (used_ext >= limit);
  assign hit_slot = SW'(cmp_ptr_q) + SW'(FIXED_SLOTS);
  assign new_slot = SW'(used_count_q);

  always_comb begin
    state_d      = state_q;
    max_pairs_d  = max_pairs_we_i ? max_pairs_i : max_pairs_q;
    used_count_d = used_count_q;
    ptr_d        = ptr_q;
    cmp_ptr_d    = cmp_ptr_q;
    cmp_valid_d  = 1'b0;
    key_d        = key_q;
    done_d       = 1'b0;
    pair_index_d = pair_index_q;
    newly_d      = 1'b0;
    full_d       = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d = {fg_color_i, bg_color_i};
          if (opcode_i == OP_CLEAR) begin
            used_count_d = UW'(FIXED_SLOTS);
            done_d       = 1'b1;
            pair_index_d = '0;
          end else if (fg_color_i < COLOR_W'(8) && bg_color_i < COLOR_W'(8)) begin
            done_d       = 1'b1;
            pair_index_d = PAIR_INDEX_W'({fg_color_i[2:0], bg_color_i[2:0]});
          end else begin
            state_d = ST_SCAN;
            ptr_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one slot ahead of the compare, one slot a cycle.
        if (cmp_valid_q && ram_rdata == key_q) begin
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          pair_index_d = hit_slot[PAIR_INDEX_W-1:0];
        end else if (ptr_q < used_dyn) begin
          ram_re      = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_ptr_d   = ptr_q;
          ptr_d       = ptr_q + UW'(1);
        end else begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (no_free) begin
            pair_index_d = '0;
            full_d       = 1'b1;
          end else begin
            ram_we       = 1'b1;
            pair_index_d = new_slot[PAIR_INDEX_W-1:0];
            newly_d      = 1'b1;
            used_count_d = used_count_q + UW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_pairs_q  <= MAX_PAIRS_RESET;
      used_count_q <= UW'(FIXED_SLOTS);
      ptr_q        <= '0;
      cmp_ptr_q    <= '0;
      cmp_valid_q  <= 1'b0;
      key_q        <= '0;
      done_q       <= 1'b0;
      pair_index_q <= '0;
      newly_q      <= 1'b0;
      full_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      max_pairs_q  <= max_pairs_d;
      used_count_q <= used_count_d;
      ptr_q        <= ptr_d;
      cmp_ptr_q    <= cmp_ptr_d;
      cmp_valid_q  <= cmp_valid_d;
      key_q        <= key_d;
      done_q       <= done_d;
      pair_index_q <= pair_index_d;
      newly_q      <= newly_d;
      full_q       <= full_d;
    end
  end

  cpla_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DYN_SLOTS)
  ) u_pair_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(used_dyn[AW-1:0]),
    .wdata_i(key_q),
    .re_i   (ram_re),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign pair_index_o      = pair_index_q;
  assign newly_allocated_o = newly_q;
  assign table_full_o      = full_q;

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q >= UW'(FIXED_SLOTS) && used_count_q <= UW'(PAIR_CAPACITY))
    else $error("used slot count out of range");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(newly_allocated_o && table_full_o))
    else $error("new slot and full table reported together");

  a_alloc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && newly_allocated_o) |-> used_count_q == $past(used_count_q) + UW'(1))
    else $error("allocation did not advance the used count");

  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_CLEAR ||
      (fg_color_i < COLOR_W'(8) && bg_color_i < COLOR_W'(8)))) |=> done_o && !busy_o)
    else $error("fixed slot or clear item did not finish in one cycle");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ptr_q <= used_dyn)
    else $error("scan pointer passed the used slots");
`endif

endmodule
